[design/fsp_pkg.sv]
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared types and codes for the FLV tag stream parser.
// ----------------------------------------------------------------------------
package fsp_pkg;

    localparam int TAG_HEADER_BYTES  = 11;
    localparam int FILE_HEADER_BYTES = 9;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_TAG = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LAST_TAG  = 2'd1;

    localparam logic [31:0] FLV_SIGNATURE = 32'h464C_5601;

    localparam logic [4:0] TYPE_AUDIO  = 5'd8;
    localparam logic [4:0] TYPE_VIDEO  = 5'd9;
    localparam logic [4:0] TYPE_SCRIPT = 5'd18;
    localparam logic [3:0] CODEC_AAC   = 4'd10;
    localparam logic [3:0] CODEC_AVC   = 4'd7;
    localparam logic [7:0] AVC_PKT_NALU = 8'd1;

    // parser phases
    localparam logic [3:0] PH_FILE  = 4'd0;
    localparam logic [3:0] PH_PREV0 = 4'd1;
    localparam logic [3:0] PH_PREV  = 4'd2;
    localparam logic [3:0] PH_TAG   = 4'd3;
    localparam logic [3:0] PH_SKIP  = 4'd4;
    localparam logic [3:0] PH_AUD   = 4'd5;
    localparam logic [3:0] PH_VID   = 4'd6;
    localparam logic [3:0] PH_NLEN  = 4'd7;
    localparam logic [3:0] PH_NHDR  = 4'd8;
    localparam logic [3:0] PH_NBODY = 4'd9;
    localparam logic [3:0] PH_FAIL  = 4'd10;

    // event codes
    localparam logic [3:0] EV_FILE_HDR   = 4'd0;
    localparam logic [3:0] EV_TAG_HDR    = 4'd1;
    localparam logic [3:0] EV_AUDIO      = 4'd2;
    localparam logic [3:0] EV_VIDEO      = 4'd3;
    localparam logic [3:0] EV_NALU       = 4'd4;
    localparam logic [3:0] EV_BAD_SIG    = 4'd5;
    localparam logic [3:0] EV_BAD_OFFSET = 4'd6;
    localparam logic [3:0] EV_PREV_SIZE  = 4'd7;
    localparam logic [3:0] EV_BAD_TYPE   = 4'd8;
    localparam logic [3:0] EV_TOO_SHORT  = 4'd9;
    localparam logic [3:0] EV_NALU_SIZE  = 4'd10;
    localparam logic [3:0] EV_NALU_FRAME = 4'd11;
    localparam logic [3:0] EV_TRUNCATED  = 4'd12;
    localparam logic [3:0] EV_RANGE_END  = 4'd13;
    localparam logic [3:0] EV_EOS        = 4'd14;

    // how many field groups an event carries
    localparam logic [1:0] LVL_INDEX = 2'd0;
    localparam logic [1:0] LVL_TAG   = 2'd1;
    localparam logic [1:0] LVL_MEDIA = 2'd2;
    localparam logic [1:0] LVL_NALU  = 2'd3;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [4:0]  tag_type;
        logic [31:0] tag_index;
        logic [23:0] tag_data_len;
        logic [31:0] time_stamp;
        logic [3:0]  codec_id;
        logic [3:0]  media_flags;
        logic [7:0]  packet_type;
        logic [23:0] cts_offset;
        logic [31:0] nal_length;
        logic [1:0]  nalu_ref_idc;
        logic [4:0]  nalu_type;
    } fsp_result_t;

    typedef struct packed {
        logic [31:0] first_tag_index;
        logic [31:0] last_tag_index;
    } fsp_cfg_t;

endpackage

[design/fsp_if.sv]
// ----------------------------------------------------------------------------
// fsp_if
// Byte request channel and event request channel of the parser.
// ----------------------------------------------------------------------------
interface fsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface fsp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  event_res;
    logic [4:0]  tag_type;
    logic [31:0] tag_index;
    logic [23:0] tag_data_len;
    logic [31:0] time_stamp;
    logic [3:0]  codec_id;
    logic [3:0]  media_flags;
    logic [7:0]  packet_type;
    logic [23:0] cts_offset;
    logic [31:0] nal_length;
    logic [1:0]  nalu_ref_idc;
    logic [4:0]  nalu_type;

    modport source (output valid, output event_res, output tag_type, output tag_index,
                    output tag_data_len, output time_stamp, output codec_id,
                    output media_flags, output packet_type, output cts_offset,
                    output nal_length, output nalu_ref_idc, output nalu_type,
                    input ready);
    modport sink   (input valid, input event_res, input tag_type, input tag_index,
                    input tag_data_len, input time_stamp, input codec_id,
                    input media_flags, input packet_type, input cts_offset,
                    input nal_length, input nalu_ref_idc, input nalu_type,
                    output ready);
endinterface

[design/flv_tag_stream_parser.sv]
// ----------------------------------------------------------------------------
// flv_tag_stream_parser
// Path: a byte taken on the request channel passes the input register and
// the decode step into the event register.
// Throughput: one byte per cycle; the decode step between the input and
// event registers holds only while the event register is full and stalled.
// Reset: asynchronous, active low; parser returns to the file header and
// the range registers to first 0, last all ones.
// ----------------------------------------------------------------------------
module flv_tag_stream_parser (
    input  logic                               clk,
    input  logic                               rst_n,
    fsp_in_if.sink                             in_item,
    fsp_out_if.source                          out_item,
    input  logic                               cfg_we,
    input  logic [fsp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fsp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import fsp_pkg::*;

    fsp_cfg_t    cfg_reg;
    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        in_eos_reg;
    logic        out_vld_reg;
    fsp_result_t out_reg;
    logic        advance;
    logic        res_valid;
    fsp_result_t res;

    assign advance       = in_vld_reg && (!out_vld_reg || out_item.ready);
    assign in_item.ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.first_tag_index <= 32'd0;
            cfg_reg.last_tag_index  <= 32'hFFFF_FFFF;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FIRST_TAG: cfg_reg.first_tag_index <= cfg_data;
                CFG_LAST_TAG:  cfg_reg.last_tag_index  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (in_item.ready)
                in_vld_reg <= in_item.valid;
            if (advance && res_valid)
                out_vld_reg <= 1'b1;
            else if (out_item.ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_item.ready && in_item.valid) begin
            in_byte_reg <= in_item.data_byte;
            in_eos_reg  <= in_item.end_of_stream;
        end
        if (advance && res_valid)
            out_reg <= res;
    end

    fsp_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .data_byte     (in_byte_reg),
        .end_of_stream (in_eos_reg),
        .cfg           (cfg_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    assign out_item.valid        = out_vld_reg;
    assign out_item.event_res    = out_reg.event_res;
    assign out_item.tag_type     = out_reg.tag_type;
    assign out_item.tag_index    = out_reg.tag_index;
    assign out_item.tag_data_len = out_reg.tag_data_len;
    assign out_item.time_stamp   = out_reg.time_stamp;
    assign out_item.codec_id     = out_reg.codec_id;
    assign out_item.media_flags  = out_reg.media_flags;
    assign out_item.packet_type  = out_reg.packet_type;
    assign out_item.cts_offset   = out_reg.cts_offset;
    assign out_item.nal_length   = out_reg.nal_length;
    assign out_item.nalu_ref_idc = out_reg.nalu_ref_idc;
    assign out_item.nalu_type    = out_reg.nalu_type;

endmodule

[design/fsp_core.sv]
// ----------------------------------------------------------------------------
// fsp_core
// Parser state and the per-byte decode step; one byte per enabled cycle.
// ----------------------------------------------------------------------------
module fsp_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic                end_of_stream,
    input  fsp_pkg::fsp_cfg_t   cfg,
    output logic                res_valid,
    output fsp_pkg::fsp_result_t res
);
    import fsp_pkg::*;

    logic [3:0]  phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [31:0] shift_reg, shift_next;
    logic [23:0] tag_left_reg, tag_left_next;
    logic [23:0] nalu_left_reg, nalu_left_next;
    logic [31:0] tag_cnt_reg, tag_cnt_next;
    logic [31:0] exp_prev_reg, exp_prev_next;
    logic [4:0]  type_reg, type_next;
    logic [23:0] size_reg, size_next;
    logic [31:0] stamp_reg, stamp_next;
    logic        halted_reg, halted_next;
    logic [3:0]  pend_reg, pend_next;
    logic [3:0]  codec_reg, codec_next;
    logic [3:0]  flags_reg, flags_next;
    logic [7:0]  pkt_reg, pkt_next;
    logic [23:0] pts_reg, pts_next;
    logic [31:0] nsize_reg, nsize_next;
    logic [1:0]  nref_reg, nref_next;
    logic [4:0]  ntype_reg, ntype_next;

    logic [3:0]  ev;
    logic [1:0]  lvl;
    logic        file_evt;
    logic [23:0] left;

    always_comb
    begin
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        shift_next     = shift_reg;
        tag_left_next  = tag_left_reg;
        nalu_left_next = nalu_left_reg;
        tag_cnt_next   = tag_cnt_reg;
        exp_prev_next  = exp_prev_reg;
        type_next      = type_reg;
        size_next      = size_reg;
        stamp_next     = stamp_reg;
        halted_next    = halted_reg;
        pend_next      = pend_reg;
        codec_next     = codec_reg;
        flags_next     = flags_reg;
        pkt_next       = pkt_reg;
        pts_next       = pts_reg;
        nsize_next     = nsize_reg;
        nref_next      = nref_reg;
        ntype_next     = ntype_reg;
        res_valid      = 1'b0;
        ev             = EV_FILE_HDR;
        lvl            = LVL_INDEX;
        file_evt       = 1'b0;
        left           = tag_left_reg;

        if (!halted_reg) begin
            if (end_of_stream) begin
                res_valid   = 1'b1;
                halted_next = 1'b1;
                if (phase_reg == PH_FAIL)
                    ev = pend_reg;
                else if (cnt_reg == 4'd0 && (phase_reg == PH_PREV0 ||
                         phase_reg == PH_PREV || phase_reg == PH_TAG))
                    ev = EV_EOS;
                else
                    ev = EV_TRUNCATED;
            end else begin
                unique case (phase_reg) inside
                    PH_FILE:
                    begin
                        if (cnt_reg != 4'd4)
                            shift_next = {shift_reg[23:0], data_byte};
                        if (cnt_reg == 4'd3 && shift_next != FLV_SIGNATURE) begin
                            res_valid = 1'b1; halted_next = 1'b1; ev = EV_BAD_SIG;
                        end else begin
                            if (cnt_reg == 4'd4)
                                flags_next = {1'b0, data_byte[2], 1'b0, data_byte[0]};
                            if (cnt_reg == 4'd8) begin
                                res_valid = 1'b1;
                                if (shift_next != 32'(FILE_HEADER_BYTES)) begin
                                    halted_next = 1'b1; ev = EV_BAD_OFFSET;
                                end else begin
                                    phase_next = PH_PREV0;
                                    cnt_next   = 4'd0;
                                    ev         = EV_FILE_HDR;
                                    file_evt   = 1'b1;
                                    flags_next = 4'd0;
                                end
                            end else begin
                                cnt_next = cnt_reg + 4'd1;
                            end
                        end
                    end
                    PH_PREV0, PH_PREV:
                    begin
                        shift_next = {shift_reg[23:0], data_byte};
                        if (cnt_reg < 4'd3) begin
                            cnt_next = cnt_reg + 4'd1;
                        end else begin
                            cnt_next = 4'd0;
                            if (shift_next != exp_prev_reg) begin
                                res_valid = 1'b1; halted_next = 1'b1; ev = EV_PREV_SIZE;
                            end else begin
                                tag_cnt_next = tag_cnt_reg + 32'd1;
                                if (phase_reg == PH_PREV && tag_cnt_next > cfg.last_tag_index)
                                begin
                                    res_valid = 1'b1; halted_next = 1'b1; ev = EV_RANGE_END;
                                end else begin
                                    phase_next = PH_TAG;
                                end
                            end
                        end
                    end
                    PH_TAG:
                    begin
                        case (cnt_reg) inside
                            4'd0:
                            begin
                                type_next  = data_byte[4:0];
                                size_next  = 24'd0;
                                stamp_next = 32'd0;
                            end
                            4'd1, 4'd2, 4'd3: size_next = {size_reg[15:0], data_byte};
                            4'd4, 4'd5, 4'd6: stamp_next = {8'd0, stamp_reg[15:0], data_byte};
                            4'd7: stamp_next = {stamp_reg[31:24] | data_byte, stamp_reg[23:0]};
                            default: ;
                        endcase
                        if (cnt_reg < 4'(TAG_HEADER_BYTES - 1)) begin
                            cnt_next = cnt_reg + 4'd1;
                        end else begin
                            cnt_next      = 4'd0;
                            exp_prev_next = 32'(TAG_HEADER_BYTES) + {8'd0, size_reg};
                            tag_left_next = size_reg;
                            codec_next = 4'd0; flags_next = 4'd0; pkt_next = 8'd0;
                            pts_next   = 24'd0; nsize_next = 32'd0;
                            nref_next  = 2'd0; ntype_next = 5'd0;
                            if (tag_cnt_reg < cfg.first_tag_index) begin
                                phase_next = (size_reg != 24'd0) ? PH_SKIP : PH_PREV;
                            end else begin
                                res_valid = 1'b1;
                                ev        = EV_TAG_HDR;
                                lvl       = LVL_TAG;
                                // errors on this tag go out on the next request
                                if (type_reg == TYPE_AUDIO) begin
                                    if (size_reg < 24'd2) begin
                                        phase_next = PH_FAIL; pend_next = EV_TOO_SHORT;
                                    end else
                                        phase_next = PH_AUD;
                                end else if (type_reg == TYPE_VIDEO) begin
                                    if (size_reg < 24'd5) begin
                                        phase_next = PH_FAIL; pend_next = EV_TOO_SHORT;
                                    end else
                                        phase_next = PH_VID;
                                end else if (type_reg == TYPE_SCRIPT) begin
                                    phase_next = (size_reg != 24'd0) ? PH_SKIP : PH_PREV;
                                end else begin
                                    phase_next = PH_FAIL; pend_next = EV_BAD_TYPE;
                                end
                            end
                        end
                    end
                    PH_FAIL:
                    begin
                        res_valid = 1'b1; halted_next = 1'b1; ev = pend_reg;
                    end
                    default:
                    begin
                        tag_left_next = left - 24'd1;
                        case (phase_reg)
                            PH_AUD:
                            begin
                                if (cnt_reg == 4'd0) begin
                                    codec_next = data_byte[7:4];
                                    flags_next = data_byte[3:0];
                                    if (data_byte[7:4] == CODEC_AAC)
                                        cnt_next = 4'd1;
                                    else begin
                                        phase_next = PH_SKIP;
                                        res_valid = 1'b1; ev = EV_AUDIO; lvl = LVL_MEDIA;
                                    end
                                end else begin
                                    pkt_next   = data_byte;
                                    cnt_next   = 4'd0;
                                    phase_next = PH_SKIP;
                                    res_valid = 1'b1; ev = EV_AUDIO; lvl = LVL_MEDIA;
                                end
                            end
                            PH_VID:
                            begin
                                if (cnt_reg == 4'd0) begin
                                    flags_next = data_byte[7:4];
                                    codec_next = data_byte[3:0];
                                    if (data_byte[3:0] == CODEC_AVC)
                                        cnt_next = 4'd1;
                                    else begin
                                        phase_next = PH_SKIP;
                                        res_valid = 1'b1; ev = EV_VIDEO; lvl = LVL_MEDIA;
                                    end
                                end else if (cnt_reg == 4'd1) begin
                                    pkt_next = data_byte;
                                    cnt_next = 4'd2;
                                end else begin
                                    pts_next = {pts_reg[15:0], data_byte};
                                    if (cnt_reg < 4'd4)
                                        cnt_next = cnt_reg + 4'd1;
                                    else begin
                                        cnt_next   = 4'd0;
                                        phase_next = (pkt_reg == AVC_PKT_NALU) ? PH_NLEN
                                                                               : PH_SKIP;
                                        res_valid = 1'b1; ev = EV_VIDEO; lvl = LVL_MEDIA;
                                    end
                                end
                            end
                            PH_NLEN:
                            begin
                                if (cnt_reg == 4'd0 && left <= 24'd4) begin
                                    res_valid = 1'b1; halted_next = 1'b1; ev = EV_NALU_FRAME;
                                end else begin
                                    shift_next = {shift_reg[23:0], data_byte};
                                    if (cnt_reg < 4'd3)
                                        cnt_next = cnt_reg + 4'd1;
                                    else begin
                                        cnt_next = 4'd0;
                                        if (shift_next > {8'd0, tag_left_next}) begin
                                            res_valid = 1'b1; halted_next = 1'b1;
                                            ev = EV_NALU_SIZE;
                                        end else if (shift_next == 32'd0) begin
                                            res_valid = 1'b1; halted_next = 1'b1;
                                            ev = EV_NALU_FRAME;
                                        end else begin
                                            nsize_next = shift_next;
                                            nref_next  = 2'd0;
                                            ntype_next = 5'd0;
                                            phase_next = PH_NHDR;
                                        end
                                    end
                                end
                            end
                            PH_NHDR:
                            begin
                                nref_next      = data_byte[6:5];
                                ntype_next     = data_byte[4:0];
                                nalu_left_next = nsize_reg[23:0] - 24'd1;
                                phase_next     = (nalu_left_next != 24'd0) ? PH_NBODY : PH_NLEN;
                                res_valid = 1'b1; ev = EV_NALU; lvl = LVL_NALU;
                            end
                            PH_NBODY:
                            begin
                                nalu_left_next = nalu_left_reg - 24'd1;
                                if (nalu_left_next == 24'd0)
                                    phase_next = PH_NLEN;
                            end
                            default: ;
                        endcase
                        // tag payload used up: back to the size word
                        if (!halted_next && tag_left_next == 24'd0) begin
                            phase_next = PH_PREV;
                            cnt_next   = 4'd0;
                        end
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res              = '0;
        res.event_res    = ev;
        res.tag_index    = tag_cnt_next;
        if (lvl != LVL_INDEX) begin
            res.tag_type     = type_next;
            res.tag_data_len = size_next;
            res.time_stamp   = stamp_next;
        end
        if (lvl == LVL_MEDIA || lvl == LVL_NALU) begin
            res.codec_id    = codec_next;
            res.media_flags = flags_next;
            res.packet_type = pkt_next;
            res.cts_offset  = pts_next;
        end
        if (lvl == LVL_NALU) begin
            res.nal_length   = nsize_next;
            res.nalu_ref_idc = nref_next;
            res.nalu_type    = ntype_next;
        end
        if (file_evt)
            res.media_flags = flags_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_FILE;
            cnt_reg       <= 4'd0;
            shift_reg     <= 32'd0;
            tag_left_reg  <= 24'd0;
            nalu_left_reg <= 24'd0;
            tag_cnt_reg   <= 32'd0;
            exp_prev_reg  <= 32'd0;
            type_reg      <= 5'd0;
            size_reg      <= 24'd0;
            stamp_reg     <= 32'd0;
            halted_reg    <= 1'b0;
            pend_reg      <= 4'd0;
            codec_reg     <= 4'd0;
            flags_reg     <= 4'd0;
            pkt_reg       <= 8'd0;
            pts_reg       <= 24'd0;
            nsize_reg     <= 32'd0;
            nref_reg      <= 2'd0;
            ntype_reg     <= 5'd0;
        end else if (step) begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            shift_reg     <= shift_next;
            tag_left_reg  <= tag_left_next;
            nalu_left_reg <= nalu_left_next;
            tag_cnt_reg   <= tag_cnt_next;
            exp_prev_reg  <= exp_prev_next;
            type_reg      <= type_next;
            size_reg      <= size_next;
            stamp_reg     <= stamp_next;
            halted_reg    <= halted_next;
            pend_reg      <= pend_next;
            codec_reg     <= codec_next;
            flags_reg     <= flags_next;
            pkt_reg       <= pkt_next;
            pts_reg       <= pts_next;
            nsize_reg     <= nsize_next;
            nref_reg      <= nref_next;
            ntype_reg     <= ntype_next;
        end
    end

endmodule

[design/fsp_checker.sv]
// ----------------------------------------------------------------------------
// fsp_checker
// Port-level checks on the event channel of the parser.
// ----------------------------------------------------------------------------
module fsp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [3:0]  event_res,
    input  logic [4:0]  tag_type,
    input  logic [31:0] tag_index,
    input  logic [23:0] tag_data_len
);
    import fsp_pkg::*;

    logic stopped_reg;

    // parser stops after an error, range end or end of stream
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stopped_reg <= 1'b0;
        else if (out_valid && out_ready && event_res >= EV_BAD_SIG)
            stopped_reg <= 1'b1;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res))
        else $error("stalled event changed");

    a_no_after_stop: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> !out_valid)
        else $error("event after parser stop");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> event_res <= EV_EOS)
        else $error("event code out of range");

    a_file_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_FILE_HDR |-> tag_index == 32'd0)
        else $error("file header event with nonzero tag index");

    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res >= EV_BAD_SIG |-> tag_type == 5'd0 && tag_data_len == 24'd0)
        else $error("error event carries tag fields");

endmodule

bind flv_tag_stream_parser fsp_checker u_fsp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_item.valid),
    .out_ready    (out_item.ready),
    .event_res    (out_item.event_res),
    .tag_type     (out_item.tag_type),
    .tag_index    (out_item.tag_index),
    .tag_data_len (out_item.tag_data_len)
);
